/* hdl/hrr_pkg.sv */
// Shared types and constants for the heartbeat round-robin dispatcher.
// Holds command/status codes, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package hrr_pkg;

	// Field widths fixed by the item format
	localparam int CMD_W     = 3;
	localparam int SLOT_W    = 4;
	localparam int ADDR_W    = 32;
	localparam int PORT_W    = 16;
	localparam int TIME_W    = 32;
	localparam int TO_W      = 16;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 5;

	// Default table depth
	localparam int MAX_SERVERS_DEF = 16;

	// Reset value of the timeout register
	localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd10;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_REGISTER  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PICK      = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic                latch;      // capture the input item
		logic                append;     // write new entry at the table end
		logic                beat;       // refresh one entry's time
		logic                tick;       // advance the seconds counter
		logic                scan_init;  // reset compaction pointers
		logic                scan_step;  // one compaction cycle
		logic                mod_init;   // start (index+1) mod count
		logic                mod_step;   // one conditional subtract
		logic                pick_rd;    // read the picked entry
		logic                finish;     // load result registers, strobe done
		logic [STATUS_W-1:0] status;     // status code for the result
	} hrr_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             slot_ok;
		logic             empty;
		logic             scan_done;
		logic             mod_ge;
	} hrr_sts_t;

endpackage

`default_nettype wire

/* hdl/heartbeat_round_robin_dispatcher.sv */
// Top level of the heartbeat round-robin dispatcher.
// Joins hrr_ctrl and hrr_datapath; uses hrr_pkg.
//
// Usage:
//   Command channel: drive cmd, slot, server_addr, server_port with start high;
//   the item transfers at a rising edge where start is high and busy is low.
//   One result per item: done is high for exactly one cycle with status,
//   picked_addr, picked_port, picked_slot, live_count and removed_count valid.
//   The receiver cannot stall; a result not captured in its cycle is gone.
//   Configuration: cfg_wr_en/cfg_wr_data write timeout_seconds; the user must write
//   only while busy is low and no result is pending (not enforced by the block).
// Steps per command, from the transfer edge to done:
//   register, heartbeat, bad slot, empty pick, unknown command: decode, finish
//   close and tick: decode, a compaction pass over the live entries, finish;
//   the compaction pass streams one entry per cycle through the one read port
//   pick: decode, (index+1) mod count by repeated subtraction with the read
//   of the picked entry in its last step, finish
// A new item is taken in the cycle done is shown.
// Reset: table empty, round-robin index and seconds counter zero, timeout 10.
// The table memory is not cleared; entries are only read after being written.
`default_nettype none

module heartbeat_round_robin_dispatcher
	import hrr_pkg::*;
#(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [CMD_W-1:0]     cmd,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [ADDR_W-1:0]    server_addr,
	input  wire logic [PORT_W-1:0]    server_port,
	input  wire logic                 cfg_wr_en,
	input  wire logic [TO_W-1:0]      cfg_wr_data,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic [ADDR_W-1:0]         picked_addr,
	output logic [PORT_W-1:0]         picked_port,
	output logic [SLOT_W-1:0]         picked_slot,
	output logic [CNT_OUT_W-1:0]      live_count,
	output logic [CNT_OUT_W-1:0]      removed_count
);

	hrr_ctl_t ctl;
	hrr_sts_t sts;

	// Sequencer
	hrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Table and result datapath
	hrr_datapath #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.slot          (slot),
		.server_addr   (server_addr),
		.server_port   (server_port),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.status        (status),
		.picked_addr   (picked_addr),
		.picked_port   (picked_port),
		.picked_slot   (picked_slot),
		.live_count    (live_count),
		.removed_count (removed_count)
	);

	// Checks
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_transfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not raise busy");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

`default_nettype wire

/* hdl/hrr_ctrl.sv */
// Sequencing state machine of the dispatcher.
// Decodes the latched command and steps the datapath; uses hrr_pkg.
`default_nettype none

module hrr_ctrl
	import hrr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire hrr_sts_t sts,
	output hrr_ctl_t      ctl,
	output logic          busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MOD,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [STATUS_W-1:0] status_q;

	// State and result status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (sts.cmd)
						CMD_REGISTER: begin
							if (sts.full)
								status_q <= ST_FULL;
							state_q <= S_FINISH;
						end
						CMD_HEARTBEAT: begin
							if (!sts.slot_ok)
								status_q <= ST_NOSLOT;
							state_q <= S_FINISH;
						end
						CMD_CLOSE: begin
							if (sts.slot_ok) begin
								state_q <= S_SCAN;
							end else begin
								status_q <= ST_NOSLOT;
								state_q  <= S_FINISH;
							end
						end
						CMD_TICK: begin
							state_q <= S_SCAN;
						end
						CMD_PICK: begin
							if (sts.empty) begin
								status_q <= ST_NONE;
								state_q  <= S_FINISH;
							end else begin
								state_q <= S_MOD;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_SCAN: begin
					if (sts.scan_done)
						state_q <= S_FINISH;
				end
				S_MOD: begin
					if (!sts.mod_ge)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath commands
	always_comb begin
		ctl           = '0;
		ctl.latch     = (state_q == S_IDLE) && start;
		ctl.append    = (state_q == S_DECODE) && (sts.cmd == CMD_REGISTER) && !sts.full;
		ctl.beat      = (state_q == S_DECODE) && (sts.cmd == CMD_HEARTBEAT) && sts.slot_ok;
		ctl.tick      = (state_q == S_DECODE) && (sts.cmd == CMD_TICK);
		ctl.scan_init = (state_q == S_DECODE) &&
			(((sts.cmd == CMD_CLOSE) && sts.slot_ok) || (sts.cmd == CMD_TICK));
		ctl.scan_step = (state_q == S_SCAN);
		ctl.mod_init  = (state_q == S_DECODE) && (sts.cmd == CMD_PICK) && !sts.empty;
		ctl.mod_step  = (state_q == S_MOD) && sts.mod_ge;
		ctl.pick_rd   = (state_q == S_MOD) && !sts.mod_ge;
		ctl.finish    = (state_q == S_FINISH);
		ctl.status    = status_q;
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* hdl/hrr_datapath.sv */
// Server table, counters and result registers of the dispatcher.
// Driven by hrr_ctrl through hrr_ctl_t; uses hrr_pkg.
`default_nettype none

module hrr_datapath
	import hrr_pkg::*;
#(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hrr_ctl_t             ctl,
	output hrr_sts_t                  sts,
	input  wire logic [CMD_W-1:0]     cmd,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [ADDR_W-1:0]    server_addr,
	input  wire logic [PORT_W-1:0]    server_port,
	input  wire logic                 cfg_wr_en,
	input  wire logic [TO_W-1:0]      cfg_wr_data,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic [ADDR_W-1:0]         picked_addr,
	output logic [PORT_W-1:0]         picked_port,
	output logic [SLOT_W-1:0]         picked_slot,
	output logic [CNT_OUT_W-1:0]      live_count,
	output logic [CNT_OUT_W-1:0]      removed_count
);

	localparam int CW    = $clog2(MAX_SERVERS + 1);
	localparam int IW    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CMPW  = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int AP_W  = ADDR_W + PORT_W;

	// Latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;

	// Block state
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rr_q;
	logic [TIME_W-1:0] now_q;
	logic [TO_W-1:0]   timeout_q;

	// Compaction and modulo working registers
	logic [CW-1:0]     rd_q;
	logic [CW-1:0]     wr_q;
	logic [CW-1:0]     val_q;
	logic              rd_v_s1;
	logic [CW-1:0]     rd_idx_s1;
	logic [IW-1:0]     slot_hold_q;
	logic [CW-1:0]     removed_q;

	// Table memories: address/port word and beat time
	logic [AP_W-1:0]   mem_ap [MAX_SERVERS];
	logic [TIME_W-1:0] mem_t  [MAX_SERVERS];
	logic [AP_W-1:0]   rdata_ap_s1;
	logic [TIME_W-1:0] rdata_t_s1;

	logic              we_ap;
	logic              we_t;
	logic [IW-1:0]     waddr;
	logic [AP_W-1:0]   wdata_ap;
	logic [TIME_W-1:0] wdata_t;
	logic              re;
	logic [IW-1:0]     raddr;

	logic              issue;
	logic              keep_s1;
	logic [TIME_W-1:0] age_s1;
	logic              pick_ok;
	logic              done_q;

	// Status to the controller
	assign issue         = (rd_q < count_q);
	assign sts.cmd       = cmd_q;
	assign sts.full      = (count_q == CW'(MAX_SERVERS));
	assign sts.slot_ok   = (CMPW'(slot_q) < CMPW'(count_q));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_done = !issue && !rd_v_s1;
	assign sts.mod_ge    = (val_q >= count_q);

	// Keep test for the entry read last cycle
	assign age_s1  = now_q - rdata_t_s1;
	assign keep_s1 = (cmd_q == CMD_CLOSE) ? (rd_idx_s1 != CW'(slot_q))
	                                      : (age_s1 <= TIME_W'(timeout_q));

	// Memory write and read port select
	always_comb begin
		we_ap    = 1'b0;
		we_t     = 1'b0;
		waddr    = wr_q[IW-1:0];
		wdata_ap = rdata_ap_s1;
		wdata_t  = rdata_t_s1;
		if (ctl.append) begin
			we_ap    = 1'b1;
			we_t     = 1'b1;
			waddr    = count_q[IW-1:0];
			wdata_ap = {addr_q, port_q};
			wdata_t  = now_q;
		end else if (ctl.beat) begin
			we_t    = 1'b1;
			waddr   = IW'(slot_q);
			wdata_t = now_q;
		end else if (ctl.scan_step && rd_v_s1 && keep_s1) begin
			we_ap = 1'b1;
			we_t  = 1'b1;
		end
	end

	assign re    = (ctl.scan_step && issue) || ctl.pick_rd;
	assign raddr = ctl.pick_rd ? val_q[IW-1:0] : rd_q[IW-1:0];

	// Table storage, registered read
	always_ff @(posedge clk) begin
		if (we_ap)
			mem_ap[waddr] <= wdata_ap;
		if (we_t)
			mem_t[waddr] <= wdata_t;
		if (re) begin
			rdata_ap_s1 <= mem_ap[raddr];
			rdata_t_s1  <= mem_t[raddr];
		end
	end

	// Latched item fields
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd;
			slot_q <= slot;
			addr_q <= server_addr;
			port_q <= server_port;
		end
	end

	// Control state: counters, pointers, timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rr_q        <= '0;
			now_q       <= '0;
			timeout_q   <= TIMEOUT_RESET;
			rd_q        <= '0;
			wr_q        <= '0;
			val_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			slot_hold_q <= '0;
			removed_q   <= '0;
		end else begin
			if (cfg_wr_en)
				timeout_q <= cfg_wr_data;
			if (ctl.latch) begin
				slot_hold_q <= '0;
				removed_q   <= '0;
			end
			if (ctl.append) begin
				slot_hold_q <= count_q[IW-1:0];
				count_q     <= count_q + CW'(1);
			end
			if (ctl.beat || (ctl.scan_init && (cmd_q == CMD_CLOSE)))
				slot_hold_q <= IW'(slot_q);
			if (ctl.tick)
				now_q <= now_q + TIME_W'(1);
			if (ctl.scan_init) begin
				rd_q    <= '0;
				wr_q    <= '0;
				rd_v_s1 <= 1'b0;
			end
			// compaction: read at rd, write kept entries at wr in the cycle after the read
			if (ctl.scan_step) begin
				rd_v_s1 <= issue;
				if (issue) begin
					rd_idx_s1 <= rd_q;
					rd_q      <= rd_q + CW'(1);
				end
				if (rd_v_s1 && keep_s1)
					wr_q <= wr_q + CW'(1);
				if (!issue && !rd_v_s1) begin
					count_q   <= wr_q;
					removed_q <= count_q - wr_q;
				end
			end
			// round-robin index by repeated subtraction
			if (ctl.mod_init)
				val_q <= CW'(rr_q) + CW'(1);
			if (ctl.mod_step)
				val_q <= val_q - count_q;
			if (ctl.pick_rd) begin
				rr_q        <= val_q[IW-1:0];
				slot_hold_q <= val_q[IW-1:0];
			end
		end
	end

	// Result registers
	assign pick_ok = (cmd_q == CMD_PICK) && (ctl.status == ST_OK);

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status        <= ctl.status;
			picked_addr   <= pick_ok ? rdata_ap_s1[AP_W-1:PORT_W] : '0;
			picked_port   <= pick_ok ? rdata_ap_s1[PORT_W-1:0] : '0;
			picked_slot   <= SLOT_W'(slot_hold_q);
			live_count    <= CNT_OUT_W'(count_q);
			removed_count <= CNT_OUT_W'(removed_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= ctl.finish;
	end

	assign done = done_q;

	// Checks
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q)
		else $error("compaction write pointer passed read pointer");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the table by one");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |-> (count_q < CW'(MAX_SERVERS)))
		else $error("append into a full table");

	a_scan_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_step |=> (count_q <= $past(count_q)))
		else $error("compaction grew the table");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pick_rd |-> (val_q < count_q))
		else $error("picked index outside live entries");

endmodule

`default_nettype wire

/* tb/sv/heartbeat_round_robin_dispatcher_test.sv */
// Self-checking testbench for heartbeat_round_robin_dispatcher.
// A tracker class mirrors the server table and checks every result; uses hrr_pkg and the DUT.
// Stimulus: directed corner items, then random phases over several timeout settings.
`default_nettype none

module heartbeat_round_robin_dispatcher_test;
	import hrr_pkg::*;

	localparam int TABLE_DEPTH = MAX_SERVERS_DEF;
	localparam int QUIET_LIMIT = 2000;    // cycles with no transfer before giving up
	localparam int ITEMS_PER_PHASE = 144;
	localparam int PHASES = 8;

	// One result as seen on the result ports
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [ADDR_W-1:0]    addr;
		logic [PORT_W-1:0]    port;
		logic [SLOT_W-1:0]    slot;
		logic [CNT_OUT_W-1:0] live;
		logic [CNT_OUT_W-1:0] removed;
	} dispatch_reply_t;

	// Mirror of the server table; predicts one reply per command
	class dispatch_tracker;
		logic [ADDR_W-1:0] addr_tab[TABLE_DEPTH];
		logic [PORT_W-1:0] port_tab[TABLE_DEPTH];
		logic [TIME_W-1:0] beat_tab[TABLE_DEPTH];
		int unsigned       count;
		int unsigned       rr;
		logic [TIME_W-1:0] now;
		logic [TO_W-1:0]   timeout;
		dispatch_reply_t   replies_due[$];
		int                errors;

		function new();
			count   = 0;
			rr      = 0;
			now     = '0;
			timeout = TIMEOUT_RESET;
			errors  = 0;
		endfunction

		function void set_timeout(logic [TO_W-1:0] v);
			timeout = v;
		endfunction

		function int unsigned live();
			return count;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// Update the mirror for one accepted command and queue its reply
		function void take_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
				logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
			dispatch_reply_t r;
			int unsigned     keep;
			logic [TIME_W-1:0] age;
			r = '0;
			case (c)
				CMD_REGISTER: begin
					if (count >= TABLE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						addr_tab[count] = a;
						port_tab[count] = p;
						beat_tab[count] = now;
						r.slot = SLOT_W'(count);
						count++;
					end
				end
				CMD_HEARTBEAT: begin
					if (s < count) begin
						beat_tab[s] = now;
						r.slot = s;
					end else begin
						r.status = ST_NOSLOT;
					end
				end
				CMD_CLOSE: begin
					if (s < count) begin
						// shift later entries down over the closed one
						for (int i = s; i + 1 < count; i++) begin
							addr_tab[i] = addr_tab[i+1];
							port_tab[i] = port_tab[i+1];
							beat_tab[i] = beat_tab[i+1];
						end
						count--;
						r.slot = s;
						r.removed = CNT_OUT_W'(1);
					end else begin
						r.status = ST_NOSLOT;
					end
				end
				CMD_TICK: begin
					// advance time, then compact away stale entries in order
					now++;
					keep = 0;
					for (int i = 0; i < count; i++) begin
						age = now - beat_tab[i];
						if (age <= timeout) begin
							addr_tab[keep] = addr_tab[i];
							port_tab[keep] = port_tab[i];
							beat_tab[keep] = beat_tab[i];
							keep++;
						end
					end
					r.removed = CNT_OUT_W'(count - keep);
					count = keep;
				end
				CMD_PICK: begin
					// index is never trimmed on removal, only wrapped here
					if (count == 0) begin
						r.status = ST_NONE;
					end else begin
						rr = (rr + 1) % count;
						r.addr = addr_tab[rr];
						r.port = port_tab[rr];
						r.slot = SLOT_W'(rr);
					end
				end
				default: ;
			endcase
			r.live = CNT_OUT_W'(count);
			replies_due = {replies_due, r};
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one result with the oldest queued reply
		function void match_reply(dispatch_reply_t got);
			dispatch_reply_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			check_field("status", 64'(want.status), 64'(got.status));
			check_field("picked_addr", 64'(want.addr), 64'(got.addr));
			check_field("picked_port", 64'(want.port), 64'(got.port));
			check_field("picked_slot", 64'(want.slot), 64'(got.slot));
			check_field("live_count", 64'(want.live), 64'(got.live));
			check_field("removed_count", 64'(want.removed), 64'(got.removed));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [CMD_W-1:0]     cmd = '0;
	logic [SLOT_W-1:0]    slot = '0;
	logic [ADDR_W-1:0]    server_addr = '0;
	logic [PORT_W-1:0]    server_port = '0;
	logic                 cfg_wr_en = 1'b0;
	logic [TO_W-1:0]      cfg_wr_data = '0;
	logic                 busy;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_W-1:0]    picked_addr;
	logic [PORT_W-1:0]    picked_port;
	logic [SLOT_W-1:0]    picked_slot;
	logic [CNT_OUT_W-1:0] live_count;
	logic [CNT_OUT_W-1:0] removed_count;

	dispatch_tracker sb;
	dispatch_reply_t seen;
	int              quiet_cycles = 0;

	heartbeat_round_robin_dispatcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.slot(slot),
		.server_addr(server_addr),
		.server_port(server_port),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.status(status),
		.picked_addr(picked_addr),
		.picked_port(picked_port),
		.picked_slot(picked_slot),
		.live_count(live_count),
		.removed_count(removed_count)
	);

	always #2 clk = ~clk;

	// Result monitor and watchdog
	always @(posedge clk) begin
		if (sb != null && arst_n) begin
			if (done) begin
				seen = '{status, picked_addr, picked_port, picked_slot, live_count,
					removed_count};
				sb.match_reply(seen);
			end
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one command and hold it until the transfer
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
		int gap;
		start       <= 1'b1;
		cmd         <= c;
		slot        <= s;
		server_addr <= a;
		server_port <= p;
		do @(posedge clk); while (busy);
		sb.take_command(c, s, a, p);
		gap = draw_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every reply has come back
	task automatic wait_replies();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TO_W-1:0] v);
		wait_replies();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_timeout(v);
	endtask

	// Random command, slots biased toward live entries
	task automatic random_command(input int reg_share);
		logic [CMD_W-1:0]  c;
		logic [SLOT_W-1:0] s;
		logic [ADDR_W-1:0] a;
		int                r;
		r = $urandom_range(0, 99);
		if (r < reg_share) begin
			c = CMD_REGISTER;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30)
				c = CMD_HEARTBEAT;
			else if (r < 45)
				c = CMD_CLOSE;
			else if (r < 75)
				c = CMD_TICK;
			else if (r < 96)
				c = CMD_PICK;
			else
				c = CMD_PICK + CMD_W'($urandom_range(1, 3));
		end
		if ((c == CMD_HEARTBEAT || c == CMD_CLOSE) && sb.live() != 0
				&& $urandom_range(0, 3) != 0)
			s = SLOT_W'($urandom_range(0, sb.live() - 1));
		else
			s = SLOT_W'($urandom_range(0, 15));
		r = $urandom_range(0, 15);
		if (r == 0)
			a = '0;
		else if (r == 1)
			a = '1;
		else
			a = $urandom;
		send_item(c, s, a, PORT_W'($urandom));
	endtask

	initial begin
		logic [TO_W-1:0] phase_timeout[PHASES];
		int reg_share;
		sb = new();
		phase_timeout = '{16'd1, 16'hFFFF, 16'd3, 16'd10, 16'd0, 16'd2, 16'hFFFF, 16'd0};
		phase_timeout[4] = TO_W'($urandom_range(4, 300));
		phase_timeout[7] = TO_W'($urandom_range(301, 65534));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, wrap of the index, stale index, unknown codes
		send_item(CMD_PICK, 4'd0, '0, '0);
		send_item(CMD_HEARTBEAT, 4'd0, '1, '1);
		send_item(CMD_CLOSE, 4'd15, '0, '0);
		send_item(CMD_TICK, 4'd0, '0, '0);
		send_item(CMD_REGISTER, 4'd15, 32'h0, 16'h0);
		send_item(CMD_REGISTER, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(CMD_REGISTER, 4'd5, 32'hA5A5_5A5A, 16'h5AA5);
		repeat (4) send_item(CMD_PICK, 4'd0, '0, '0);
		send_item(CMD_HEARTBEAT, 4'd2, '0, '0);
		send_item(CMD_HEARTBEAT, 4'd3, '0, '0);
		send_item(CMD_CLOSE, 4'd0, '0, '0);
		send_item(CMD_PICK, 4'd15, '1, '1);
		send_item(CMD_PICK + CMD_W'(1), 4'd0, '0, '0);
		send_item(CMD_PICK + CMD_W'(2), 4'd9, 32'h1234_5678, 16'h9ABC);
		send_item(CMD_PICK + CMD_W'(3), 4'd15, '1, '1);
		// timeout of one: entries age out within two ticks unless refreshed
		write_timeout(16'd1);
		send_item(CMD_TICK, 4'd0, '0, '0);
		send_item(CMD_HEARTBEAT, 4'd0, '0, '0);
		send_item(CMD_TICK, 4'd0, '0, '0);
		send_item(CMD_TICK, 4'd0, '0, '0);
		send_item(CMD_PICK, 4'd0, '0, '0);

		// Random phases, each under its own timeout; the table fills under long timeouts
		for (int ph = 0; ph < PHASES; ph++) begin
			write_timeout(phase_timeout[ph]);
			reg_share = (phase_timeout[ph] > 16'd1000) ? 55 : 30;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_command(reg_share);
		end

		wait_replies();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
